// ===== sv/rpsg_pkg.sv =====
// Shared types, constants and character tables for the password shuffle generator.
package rpsg_pkg;

   localparam int MAX_LENGTH_DEF = 64;
   localparam int MIN_LENGTH     = 12;
   localparam int WORD_W         = 32;
   localparam int CFG_W          = 7;
   localparam int CSR_IDX_W      = 2;
   localparam int CHAR_W         = 7;
   localparam int SET_SIZE_MAX   = 93;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [1:0]        cls_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // register indexes
   localparam csr_idx_type REG_LENGTH  = 2'd0;
   localparam csr_idx_type REG_UPPER   = 2'd1;
   localparam csr_idx_type REG_DIGITS  = 2'd2;
   localparam csr_idx_type REG_SYMBOLS = 2'd3;

   localparam logic [CFG_W-1:0] LENGTH_RESET = 7'd16;

   // character classes
   localparam cls_type CLS_LOWER  = 2'd0;
   localparam cls_type CLS_UPPER  = 2'd1;
   localparam cls_type CLS_DIGIT  = 2'd2;
   localparam cls_type CLS_SYMBOL = 2'd3;

   localparam char_type SYMBOL_TABLE [31] = '{
      7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26, 7'h27, 7'h28,
      7'h29, 7'h2A, 7'h2B, 7'h2C, 7'h2D, 7'h2E, 7'h2F, 7'h3A,
      7'h3B, 7'h3C, 7'h3D, 7'h3E, 7'h3F, 7'h40, 7'h5B, 7'h5D,
      7'h5E, 7'h5F, 7'h60, 7'h7B, 7'h7C, 7'h7D, 7'h7E
   };

   function automatic logic [6:0] class_size(cls_type cls);
      logic [6:0] r;
      case (cls)
         CLS_LOWER:  r = 7'd26;
         CLS_UPPER:  r = 7'd26;
         CLS_DIGIT:  r = 7'd10;
         CLS_SYMBOL: r = 7'd31;
         default:    r = 7'd26;
      endcase
      return r;
   endfunction

   // k is below the size of the class
   function automatic char_type class_char(cls_type cls, logic [6:0] k);
      char_type r;
      case (cls)
         CLS_LOWER:  r = 7'(7'h61 + k);
         CLS_UPPER:  r = 7'(7'h41 + k);
         CLS_DIGIT:  r = 7'(7'h30 + k);
         CLS_SYMBOL: r = (k < 7'd31) ? SYMBOL_TABLE[k[4:0]] : 7'd0;
         default:    r = 7'd0;
      endcase
      return r;
   endfunction

   function automatic logic [6:0] set_size(logic up, logic dg, logic sy);
      logic [6:0] r;
      r = 7'd26;
      if (up) r = 7'(r + 7'd26);
      if (dg) r = 7'(r + 7'd10);
      if (sy) r = 7'(r + 7'd31);
      return r;
   endfunction

   function automatic logic [2:0] class_count(logic up, logic dg, logic sy);
      return 3'd1 + 3'(up) + 3'(dg) + 3'(sy);
   endfunction

   // class of the pos-th enabled class, lowercase always first
   function automatic cls_type class_of(logic [1:0] pos, logic up, logic dg, logic sy);
      logic [3:0] en;
      logic [2:0] seen;
      cls_type    r;
      en   = {sy, dg, up, 1'b1};
      seen = 3'd0;
      r    = CLS_LOWER;
      for (int c = 0; c < 4; c++) begin
         if (en[c]) begin
            if (seen == 3'(pos)) r = 2'(c);
            seen = 3'(seen + 3'd1);
         end
      end
      return r;
   endfunction

   // character at place k of the concatenated enabled set
   function automatic char_type set_char_at(logic [6:0] k, logic up, logic dg, logic sy);
      logic [3:0] en;
      logic [6:0] rest;
      logic       found;
      char_type   r;
      en    = {sy, dg, up, 1'b1};
      rest  = k;
      found = 1'b0;
      r     = 7'd0;
      for (int c = 0; c < 4; c++) begin
         if (en[c] && !found) begin
            if (rest < class_size(2'(c))) begin
               r     = class_char(2'(c), rest);
               found = 1'b1;
            end else begin
               rest = 7'(rest - class_size(2'(c)));
            end
         end
      end
      return r;
   endfunction

endpackage

// ===== sv/rpsg_mod_unit.sv =====
// Bit-serial 32-bit remainder unit: one restoring step per cycle.
module rpsg_mod_unit #(
   parameter int DIV_W = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rpsg_pkg::WORD_W-1:0] dividend,
   input  logic [DIV_W-1:0]            divisor,
   output logic [DIV_W-1:0]            remainder,
   output logic                        done
);

   localparam int CNT_W = $clog2(rpsg_pkg::WORD_W);

   logic [DIV_W-1:0]            rem_ff, rem_in;
   logic [DIV_W-1:0]            dsr_ff;
   logic [rpsg_pkg::WORD_W-1:0] dvd_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;
   logic [DIV_W:0]              trial;
   logic                        ge;

   assign trial  = {rem_ff, dvd_ff[rpsg_pkg::WORD_W-1]};
   assign ge     = trial >= {1'b0, dsr_ff};
   assign rem_in = ge ? DIV_W'(trial - {1'b0, dsr_ff}) : trial[DIV_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_W'(rpsg_pkg::WORD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[rpsg_pkg::WORD_W-2:0], 1'b0};
      end
   end

   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ===== sv/rpsg_buffer.sv =====
// Character buffer: one write port and one registered read port.
module rpsg_buffer #(
   parameter int DEPTH = rpsg_pkg::MAX_LENGTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  rpsg_pkg::char_type wr_data,
   input  logic [AW-1:0]      rd_addr,
   output rpsg_pkg::char_type rd_data
);

   rpsg_pkg::char_type mem [DEPTH];
   rpsg_pkg::char_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/random_password_shuffle_generator.sv =====
// Password generator: fills a buffer from random words, shuffles it, streams it out.
//
// Usage: write password_length and the three class flags through the csr_ port
// (index 0..3) while idle. Then feed 32-bit random words on the req_ channel.
// The first word of a job latches the settings. Each fill word runs the bit-serial
// remainder unit and then writes one buffer entry; shuffle words also do the
// read-read-write-write swap on the single-port-pair buffer. A job uses 2*length-1
// words; after the last one the password leaves on the rsp_ channel, each character
// read from the buffer and then loaded into the output register while the
// receiver keeps up, with rsp_tlast on the final one. If the length is below
// 12, the first word returns one beat with rsp_tuser set, data zero and tlast,
// and the block stays idle. Lengths above MAX_LENGTH are saturated.
// A stalled receiver holds the output beat; the read sweep waits on it.
// Reset is synchronous: it returns to idle, drops any pending beat and restores
// length 16 with all classes enabled. The buffer needs no clearing pass.
module random_password_shuffle_generator #(
   parameter int MAX_LENGTH = rpsg_pkg::MAX_LENGTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [31:0]                  req_tdata,   // [31:0] random_word
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [6:0] out_char, [7] zero
   output logic                         rsp_tlast,   // is_last
   output logic                         rsp_tuser,   // [0] length_error
   input  logic                         csr_wr_en,
   input  rpsg_pkg::csr_idx_type        csr_index,
   input  logic [rpsg_pkg::CFG_W-1:0]   csr_wr_data
);

   localparam int AW     = $clog2(MAX_LENGTH);
   localparam int LW     = $clog2(MAX_LENGTH + 1);
   localparam int DIVMAX = (MAX_LENGTH > rpsg_pkg::SET_SIZE_MAX) ? MAX_LENGTH
                                                                 : rpsg_pkg::SET_SIZE_MAX;
   localparam int DW     = $clog2(DIVMAX + 1);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_BUSY    = 4'd1;
   localparam logic [3:0] ST_START   = 4'd2;
   localparam logic [3:0] ST_DIV     = 4'd3;
   localparam logic [3:0] ST_RDJ     = 4'd4;
   localparam logic [3:0] ST_WRI     = 4'd5;
   localparam logic [3:0] ST_WRJ     = 4'd6;
   localparam logic [3:0] ST_EMIT_RD = 4'd7;
   localparam logic [3:0] ST_EMIT_LD = 4'd8;

   // configuration registers
   logic [rpsg_pkg::CFG_W-1:0] cfg_len_ff;
   logic                       cfg_up_ff, cfg_dg_ff, cfg_sy_ff;

   // latched job settings and control
   logic [3:0]                  state_ff, state_in;
   logic [LW-1:0]               len_ff;
   logic                        up_ff, dg_ff, sy_ff;
   logic                        shuffle_ff;
   logic [AW-1:0]               idx_ff;
   logic [AW-1:0]               j_ff;
   rpsg_pkg::char_type          bi_ff;
   logic [rpsg_pkg::WORD_W-1:0] word_ff;

   logic                        rsp_valid_ff;
   rpsg_pkg::char_type          rsp_char_ff;
   logic                        rsp_last_ff, rsp_err_ff;

   logic                        slot_free;
   logic                        req_accept;
   logic                        short_len;
   logic                        beat_load;
   logic                        req_phase;
   logic                        last_fill;
   logic                        last_emit;
   rpsg_pkg::cls_type           req_cls;
   logic [DW-1:0]               divisor;
   logic [DW-1:0]               remainder;
   logic                        div_done;
   rpsg_pkg::char_type          fill_char;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr, rd_addr;
   rpsg_pkg::char_type          wr_data, rd_data;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = ((state_ff == ST_IDLE) && slot_free) || (state_ff == ST_BUSY);
   assign req_accept = req_tvalid && req_tready;
   assign short_len  = cfg_len_ff < rpsg_pkg::CFG_W'(rpsg_pkg::MIN_LENGTH);
   assign beat_load  = ((state_ff == ST_IDLE) && req_accept && short_len) ||
                       ((state_ff == ST_EMIT_LD) && slot_free);

   assign req_phase  = 32'(idx_ff) < 32'(rpsg_pkg::class_count(up_ff, dg_ff, sy_ff));
   assign req_cls    = rpsg_pkg::class_of(idx_ff[1:0], up_ff, dg_ff, sy_ff);
   assign last_fill  = idx_ff == AW'(len_ff - 1'b1);
   assign last_emit  = last_fill;

   always_comb begin
      if (shuffle_ff) divisor = DW'(32'(idx_ff) + 1);
      else if (req_phase) divisor = DW'(rpsg_pkg::class_size(req_cls));
      else divisor = DW'(rpsg_pkg::set_size(up_ff, dg_ff, sy_ff));
   end

   assign fill_char = req_phase ? rpsg_pkg::class_char(req_cls, remainder[6:0])
                                : rpsg_pkg::set_char_at(remainder[6:0], up_ff, dg_ff, sy_ff);

   rpsg_mod_unit #(.DIV_W(DW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == ST_START),
      .dividend  (word_ff),
      .divisor   (divisor),
      .remainder (remainder),
      .done      (div_done)
   );

   // buffer port steering
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = fill_char;
      rd_addr = idx_ff;
      case (state_ff)
         ST_DIV:  wr_en = div_done && !shuffle_ff;
         ST_RDJ:  rd_addr = j_ff;
         ST_WRI: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
         end
         ST_WRJ: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = bi_ff;
         end
         default: ;
      endcase
   end

   rpsg_buffer #(.DEPTH(MAX_LENGTH), .AW(AW)) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_len_ff <= rpsg_pkg::LENGTH_RESET;
         cfg_up_ff  <= 1'b1;
         cfg_dg_ff  <= 1'b1;
         cfg_sy_ff  <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            rpsg_pkg::REG_LENGTH:  cfg_len_ff <= csr_wr_data;
            rpsg_pkg::REG_UPPER:   cfg_up_ff  <= csr_wr_data[0];
            rpsg_pkg::REG_DIGITS:  cfg_dg_ff  <= csr_wr_data[0];
            rpsg_pkg::REG_SYMBOLS: cfg_sy_ff  <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_accept && !short_len) state_in = ST_START;
         ST_BUSY:    if (req_accept) state_in = ST_START;
         ST_START:   state_in = ST_DIV;
         ST_DIV:     if (div_done) state_in = shuffle_ff ? ST_RDJ : ST_BUSY;
         ST_RDJ:     state_in = ST_WRI;
         ST_WRI:     state_in = ST_WRJ;
         ST_WRJ:     state_in = (idx_ff == AW'(1)) ? ST_EMIT_RD : ST_BUSY;
         ST_EMIT_RD: state_in = ST_EMIT_LD;
         ST_EMIT_LD: if (slot_free) state_in = last_emit ? ST_IDLE : ST_EMIT_RD;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shuffle_ff   <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (beat_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && !short_len) begin
                  shuffle_ff <= 1'b0;
                  idx_ff     <= '0;
               end
            end
            ST_DIV: begin
               // a fill word advances the position; the last one starts the shuffle at len-1
               if (div_done && !shuffle_ff) begin
                  if (last_fill) shuffle_ff <= 1'b1;
                  else idx_ff <= AW'(idx_ff + 1'b1);
               end
            end
            ST_WRJ: begin
               if (idx_ff == AW'(1)) idx_ff <= '0;
               else idx_ff <= AW'(idx_ff - 1'b1);
            end
            ST_EMIT_LD: begin
               if (slot_free && !last_emit) idx_ff <= AW'(idx_ff + 1'b1);
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) word_ff <= req_tdata;
      if ((state_ff == ST_IDLE) && req_accept && !short_len) begin
         if (32'(cfg_len_ff) > MAX_LENGTH) len_ff <= LW'(MAX_LENGTH);
         else len_ff <= LW'(cfg_len_ff);
         up_ff <= cfg_up_ff;
         dg_ff <= cfg_dg_ff;
         sy_ff <= cfg_sy_ff;
      end
      if ((state_ff == ST_DIV) && div_done) j_ff <= remainder[AW-1:0];
      if (state_ff == ST_RDJ) bi_ff <= rd_data;
      if ((state_ff == ST_IDLE) && req_accept && short_len) begin
         rsp_char_ff <= '0;
         rsp_last_ff <= 1'b1;
         rsp_err_ff  <= 1'b1;
      end else if ((state_ff == ST_EMIT_LD) && slot_free) begin
         rsp_char_ff <= rd_data;
         rsp_last_ff <= last_emit;
         rsp_err_ff  <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

// ===== sv/rpsg_checker.sv =====
// Port-level checks for the password shuffle generator, bound to the top level.
module rpsg_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // an error beat always closes its run
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("error beat without tlast");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("error beat carries a character");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)
                                    && $stable(rsp_tuser))
      else $error("stalled beat changed");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("beat valid right after reset");

endmodule

bind random_password_shuffle_generator rpsg_checker u_rpsg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the random password shuffle generator.
module testbench;

   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 80;
   localparam int MAX_LEN       = rpsg_pkg::MAX_LENGTH_DEF;

   typedef struct packed {
      rpsg_pkg::char_type ch;
      logic               last;
      logic               err;
   } pw_beat_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [31:0]                   req_tdata;    // [31:0] random_word
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [7:0]                    rsp_tdata;    // [6:0] out_char, [7] zero
   logic                          rsp_tlast;    // is_last
   logic                          rsp_tuser;    // [0] length_error
   logic                          csr_wr_en;
   rpsg_pkg::csr_idx_type         csr_index;
   logic [rpsg_pkg::CFG_W-1:0]    csr_wr_data;

   random_password_shuffle_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // generator state as the block should hold it
   logic [6:0]          cfg_length;
   logic                cfg_upper;
   logic                cfg_digits;
   logic                cfg_symbols;
   logic                job_busy;
   int unsigned         job_words;
   int unsigned         job_len;
   int unsigned         class_n;
   int unsigned         pool_size;
   rpsg_pkg::cls_type   job_class [4];
   rpsg_pkg::char_type  pw_buf [MAX_LEN];
   pw_beat_type         password_queue [$];

   int send_idle_pct;
   int recv_idle_pct;
   int words_sent;
   int mismatches = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int unsigned class_span(rpsg_pkg::cls_type cls);
      case (cls)
         rpsg_pkg::CLS_LOWER, rpsg_pkg::CLS_UPPER: return 26;
         rpsg_pkg::CLS_DIGIT:                      return 10;
         default:                                  return 31;
      endcase
   endfunction

   // symbols are the printable runs around the letters and digits, without the backslash
   function automatic rpsg_pkg::char_type symbol_glyph(int unsigned k);
      if (k < 15)       return 7'(8'h21 + k);
      else if (k < 22)  return 7'(8'h3A + k - 15);
      else if (k == 22) return 7'h5B;
      else if (k < 27)  return 7'(8'h5D + k - 23);
      else              return 7'(8'h7B + k - 27);
   endfunction

   function automatic rpsg_pkg::char_type glyph_of(rpsg_pkg::cls_type cls, int unsigned k);
      case (cls)
         rpsg_pkg::CLS_LOWER: return 7'(8'h61 + k);
         rpsg_pkg::CLS_UPPER: return 7'(8'h41 + k);
         rpsg_pkg::CLS_DIGIT: return 7'(8'h30 + k);
         default:             return symbol_glyph(k);
      endcase
   endfunction

   function automatic rpsg_pkg::char_type pool_glyph(int unsigned k);
      int unsigned rest;
      rest = k;
      for (int c = 0; c < class_n; c++) begin
         if (rest < class_span(job_class[c])) return glyph_of(job_class[c], rest);
         rest = rest - class_span(job_class[c]);
      end
      return '0;
   endfunction

   function automatic void advance_generator(logic [31:0] word);
      int unsigned c;
      int unsigned i;
      int unsigned j;
      rpsg_pkg::char_type t;
      if (!job_busy) begin
         if (cfg_length < rpsg_pkg::MIN_LENGTH) begin
            password_queue.push_back(pw_beat_type'{ch: '0, last: 1'b1, err: 1'b1});
            return;
         end
         job_len = (cfg_length > MAX_LEN) ? MAX_LEN : cfg_length;
         class_n = 0;
         job_class[class_n] = rpsg_pkg::CLS_LOWER;
         class_n = class_n + 1;
         if (cfg_upper) begin
            job_class[class_n] = rpsg_pkg::CLS_UPPER;
            class_n = class_n + 1;
         end
         if (cfg_digits) begin
            job_class[class_n] = rpsg_pkg::CLS_DIGIT;
            class_n = class_n + 1;
         end
         if (cfg_symbols) begin
            job_class[class_n] = rpsg_pkg::CLS_SYMBOL;
            class_n = class_n + 1;
         end
         pool_size = 0;
         for (int k = 0; k < class_n; k++) pool_size = pool_size + class_span(job_class[k]);
         job_words = 0;
         job_busy  = 1'b1;
      end
      c = job_words;
      if (c < class_n) begin
         pw_buf[c] = glyph_of(job_class[c], word % class_span(job_class[c]));
      end else if (c < job_len) begin
         pw_buf[c] = pool_glyph(word % pool_size);
      end else begin
         // shuffle walks down from the top index
         i = job_len - 1 - (c - job_len);
         j = word % (i + 1);
         t = pw_buf[i];
         pw_buf[i] = pw_buf[j];
         pw_buf[j] = t;
      end
      job_words = c + 1;
      if (job_words >= 2 * job_len - 1) begin
         for (int k = 0; k < job_len; k++)
            password_queue.push_back(pw_beat_type'{ch: pw_buf[k], last: (k == job_len - 1),
                                                   err: 1'b0});
         job_busy  = 1'b0;
         job_words = 0;
      end
   endfunction

   function automatic logic [31:0] random_word();
      int unsigned pick;
      pick = $urandom_range(9);
      case (pick)
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom_range(255);
         default: return $urandom;
      endcase
   endfunction

   function automatic int unsigned planned_words();
      if (cfg_length < rpsg_pkg::MIN_LENGTH) return 1;
      return 2 * ((cfg_length > MAX_LEN) ? MAX_LEN : cfg_length) - 1;
   endfunction

   // enter and leave at a falling edge; valid stays high for a following beat
   task automatic send_word(input logic [31:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_generator(word);
      words_sent = words_sent + 1;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (password_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input int len, input logic up, input logic dg, input logic sy);
      settle();
      csr_wr_en   <= 1'b1;
      csr_index   <= rpsg_pkg::REG_LENGTH;
      csr_wr_data <= 7'(len);
      @(negedge clock);
      csr_index   <= rpsg_pkg::REG_UPPER;
      csr_wr_data <= 7'(up);
      @(negedge clock);
      csr_index   <= rpsg_pkg::REG_DIGITS;
      csr_wr_data <= 7'(dg);
      @(negedge clock);
      csr_index   <= rpsg_pkg::REG_SYMBOLS;
      csr_wr_data <= 7'(sy);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cfg_length  = 7'(len);
      cfg_upper   = up;
      cfg_digits  = dg;
      cfg_symbols = sy;
   endtask

   task automatic run_job();
      int unsigned n;
      n = planned_words();
      repeat (n) send_word(random_word());
   endtask

   task automatic test_reset_settings();
      run_job();
   endtask

   task automatic test_short_length();
      configure(0, 1'b1, 1'b1, 1'b1);
      send_word('0);
      configure(rpsg_pkg::MIN_LENGTH - 1, 1'b0, 1'b0, 1'b0);
      send_word('1);
   endtask

   task automatic test_min_length_job();
      configure(rpsg_pkg::MIN_LENGTH, 1'b0, 1'b0, 1'b0);
      for (int k = 0; k < 2 * rpsg_pkg::MIN_LENGTH - 1; k++)
         send_word((k % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF);
   endtask

   task automatic test_random_jobs(input int send_pct, input int recv_pct,
                                   input int long_len, input int quota);
      int first;
      int len;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      first = words_sent;
      if (long_len != 0) begin
         configure(long_len, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
         run_job();
      end
      while (words_sent - first < quota) begin
         if ($urandom_range(9) == 0) len = $urandom_range(rpsg_pkg::MIN_LENGTH - 1);
         else len = $urandom_range(20, rpsg_pkg::MIN_LENGTH);
         configure(len, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
         run_job();
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_beats
      pw_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (password_queue.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected beat: data %h last %b user %b",
                        rsp_tdata, rsp_tlast, rsp_tuser);
            mismatches = mismatches + 1;
         end else begin
            want = password_queue.pop_front();
            if (rsp_tdata !== {1'b0, want.ch} || rsp_tlast !== want.last ||
                rsp_tuser !== want.err) begin
               if (mismatches < 10)
                  $display("beat mismatch: expected data %h last %b user %b, got %h %b %b",
                           {1'b0, want.ch}, want.last, want.err,
                           rsp_tdata, rsp_tlast, rsp_tuser);
               mismatches = mismatches + 1;
            end
         end
      end
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_wr_en     = 1'b0;
      csr_index     = rpsg_pkg::REG_LENGTH;
      csr_wr_data   = '0;
      cfg_length    = rpsg_pkg::LENGTH_RESET;
      cfg_upper     = 1'b1;
      cfg_digits    = 1'b1;
      cfg_symbols   = 1'b1;
      job_busy      = 1'b0;
      job_words     = 0;
      job_len       = 0;
      class_n       = 0;
      pool_size     = 0;
      words_sent    = 0;
      send_idle_pct = 28;
      recv_idle_pct = 46;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_settings();
      test_short_length();
      test_random_jobs(46, 28, 127, 0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_min_length_job();

      settle();
      if (mismatches == 0 && password_queue.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
